// ===== rtl/asd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants for the adaptive step dequantizer
// Request payload structs, register indexes and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package asd_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 2'd2;

  // serial divider: 48-bit magnitude over an 8-bit window length
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = 6;
  localparam int LEN_W     = 8;
  localparam int POS_NUM_W = 9;

  // Q15 handling
  localparam int          Q_SHIFT  = 15;
  localparam logic [31:0] Q_ROUND  = 32'd32767;

  typedef struct packed {
    logic signed [15:0] code_in;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               block_end_out;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/adaptive_step_dequantizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_step_dequantizer: ADPCM-style decoder with a windowed adaptive step
// Scales each code by the current step, adds the prediction, and adapts the
// step from a running sum of recent difference magnitudes.
// ----------------------------------------------------------------------------
//
//   channel   signals                         direction  carries
//   --------  ------------------------------  ---------  --------------------
//   input     in_valid / in_ready / in_data   in         code_in, block_end
//   output    out_valid / out_ready / out_data out       sample_out, block_end_out
//   config    cfg_en / cfg_index / cfg_data   in         gain and length regs
//
// Requests: one at a time; the next is taken in idle only after the 48-step serial
//   divide of the scaled window sum by the window length, plus store read, multiply,
//   divider start, divider finish and hand-over.
// A finished result waits in the output register while the next request is
//   taken; only the hand-over stalls, and only while that result is unread.
// Reset: synchronous; per-entry valid bits cleared at once make the store read zero.
//
module adaptive_step_dequantizer #(
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire asd_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output asd_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_en,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [asd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [8:0] DEPTH_C = 9'(WINDOW_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_WAIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // window position folded onto the store: at most eight compare/subtract steps
  function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] p);
    logic [8:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[7:0], p[i]};
      if (r >= DEPTH_C) r = r - DEPTH_C;
    end
    return r[SLOT_W-1:0];
  endfunction

  state_t state;

  // configuration registers
  logic signed [15:0] pred_gain;
  logic signed [15:0] step_gain;
  logic [7:0]         win_len;
  logic [7:0]         len_eff;

  // decoder state
  logic signed [15:0] step_size;
  logic signed [15:0] pred;
  logic signed [15:0] prev_out;
  logic [31:0]        win_sum;
  logic [7:0]         win_pos;

  // per-request working registers
  logic [SLOT_W-1:0]  slot_r;
  logic signed [31:0] diff;
  logic signed [31:0] fb_prod;
  logic               blk_end;
  logic [15:0]        sample_r;
  logic [47:0]        scaled;

  // window store: one read port, one write port
  logic [15:0]             store [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] store_vld;
  logic [15:0]             rd_data;
  logic                    rd_vld;

  logic                    accept;
  logic [SLOT_W-1:0]       slot;
  logic [31:0]             mag;
  logic [15:0]             old_mag;
  logic [31:0]             sum_next;
  logic [31:0]             fb_adj;
  logic [15:0]             fb16;
  logic [15:0]             sample;
  logic [15:0]             gain_abs;
  logic                    out_free;

  logic                    div_start;
  logic                    div_done;
  logic [47:0]             quotient;
  logic [7:0]              pos_rem;
  logic [48:0]             t_signed;
  logic [15:0]             step_new;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign len_eff   = (win_len == 8'd0) ? 8'd1 : win_len;
  assign slot      = slot_of(win_pos);
  assign out_free  = !out_valid || out_ready;
  assign div_start = (state == S_START);

  // |diff|, running sum update with the entry it replaces
  assign mag      = diff[31] ? 32'(-diff) : 32'(diff);
  assign old_mag  = rd_vld ? rd_data : 16'd0;
  assign sum_next = win_sum - {16'd0, old_mag} + mag;

  // feedback term: Q15 product truncated toward zero
  assign fb_adj = fb_prod[31] ? 32'(fb_prod + $signed(asd_pkg::Q_ROUND))
                              : 32'(fb_prod);
  assign fb16   = fb_adj[asd_pkg::Q_SHIFT +: 16];
  assign sample = diff[15:0] + pred;

  assign gain_abs = step_gain[15] ? 16'(-step_gain) : 16'(step_gain);

  // signed quotient, then floor shift by 15 taken as a bit slice
  assign t_signed = step_gain[15] ? 49'(-{1'b0, quotient}) : {1'b0, quotient};
  assign step_new = t_signed[asd_pkg::Q_SHIFT +: 16];

  asd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled),
    .divisor  (len_eff),
    .pos_num  (9'({1'b0, win_pos}) + 9'd1),
    .done     (div_done),
    .quotient (quotient),
    .pos_rem  (pos_rem)
  );

  // window store
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[slot];
    end
    if (state == S_READ) begin
      store[slot_r] <= mag[15:0];
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pred_gain <= '0;
      step_gain <= 16'sd32767;
      win_len   <= 8'd1;
      step_size <= 16'sd1;
      pred      <= '0;
      prev_out  <= '0;
      win_sum   <= '0;
      win_pos   <= '0;
      store_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_en) begin
        case (cfg_index)
          asd_pkg::CFG_PRED_GAIN: pred_gain <= cfg_data;
          asd_pkg::CFG_STEP_GAIN: step_gain <= cfg_data;
          asd_pkg::CFG_WIN_LEN:   win_len   <= cfg_data[7:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_vld <= store_vld[slot];
            state  <= S_READ;
          end
        end
        S_READ: begin
          win_sum           <= sum_next;
          store_vld[slot_r] <= 1'b1;
          prev_out          <= sample;
          pred              <= sample - fb16;
          state             <= S_MUL;
        end
        S_MUL: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            step_size <= (step_new == 16'd0) ? 16'sd1 : step_new;
            win_pos   <= pos_rem;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r  <= slot;
      diff    <= in_data.code_in * step_size;
      fb_prod <= pred_gain * prev_out;
      blk_end <= in_data.block_end;
    end
    if (state == S_READ) begin
      sample_r <= sample;
    end
    if (state == S_MUL) begin
      scaled <= 48'(win_sum) * 48'(gain_abs);
    end
    if ((state == S_OUT) && out_free) begin
      out_data.sample_out    <= sample_r;
      out_data.block_end_out <= blk_end;
    end
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted request did not move to store read");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT))
    else $error("divider finished outside the wait state");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    step_size != 16'sd0)
    else $error("step size reached zero");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_free) |=> (win_pos < len_eff))
    else $error("window position beyond window length");

  a_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (state == S_IDLE))
    else $error("result raised without returning to idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/asd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asd_div: restoring serial divider
// One quotient bit per cycle over a 48-bit dividend by an 8-bit divisor; the
// next window position remainder is worked out alongside in the first steps.
// ----------------------------------------------------------------------------
module asd_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [asd_pkg::DIV_W-1:0]          dividend,
  input  wire logic [asd_pkg::LEN_W-1:0]          divisor,
  input  wire logic [asd_pkg::POS_NUM_W-1:0]      pos_num,
  output logic                                    done,
  output logic [asd_pkg::DIV_W-1:0]               quotient,
  output logic [asd_pkg::LEN_W-1:0]               pos_rem
);

  localparam logic [asd_pkg::DIV_CNT_W-1:0] LAST_STEP =
    asd_pkg::DIV_CNT_W'(asd_pkg::DIV_W - 1);
  localparam logic [asd_pkg::DIV_CNT_W-1:0] POS_STEPS =
    asd_pkg::DIV_CNT_W'(asd_pkg::POS_NUM_W);

  logic                                busy;
  logic [asd_pkg::DIV_CNT_W-1:0]       cnt;
  logic [asd_pkg::DIV_W-1:0]           num;
  logic [asd_pkg::LEN_W-1:0]           rem;
  logic [asd_pkg::POS_NUM_W-1:0]       pnum;
  logic [asd_pkg::LEN_W-1:0]           prem;

  logic [asd_pkg::LEN_W:0] trial, ptrial, dvs;
  logic                    ge, pge;

  assign dvs    = {1'b0, divisor};
  assign trial  = {rem, num[asd_pkg::DIV_W-1]};
  assign ge     = trial >= dvs;
  assign ptrial = {prem, pnum[asd_pkg::POS_NUM_W-1]};
  assign pge    = ptrial >= dvs;

  assign quotient = num;
  assign pos_rem  = prem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      rem  <= '0;
      pnum <= pos_num;
      prem <= '0;
    end else if (busy) begin
      num <= {num[asd_pkg::DIV_W-2:0], ge};
      rem <= ge ? asd_pkg::LEN_W'(trial - dvs) : trial[asd_pkg::LEN_W-1:0];
      if (cnt < POS_STEPS) begin
        pnum <= {pnum[asd_pkg::POS_NUM_W-2:0], 1'b0};
        prem <= pge ? asd_pkg::LEN_W'(ptrial - dvs) : ptrial[asd_pkg::LEN_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/asd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asd_checker: sample predictor and scoreboard for the adaptive step dequantizer
// Follows register writes, predicts the reconstructed sample for every accepted
// code request and compares returned samples against them in order.
// ----------------------------------------------------------------------------
module asd_checker #(
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire asd_pkg::in_item_t              in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire asd_pkg::out_item_t             out_data,
  input  wire logic                           cfg_en,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [asd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  due_count,
  output int                                  checked_count
);

  // register copies
  logic signed [15:0] pred_gain;
  logic signed [15:0] step_gain;
  logic [7:0]         win_len;

  // decoder state
  logic signed [15:0] step_now;
  logic signed [15:0] pred_now;
  logic signed [15:0] last_sample;
  logic [31:0]        mag_sum;
  logic [15:0]        mag_hist [WINDOW_DEPTH];
  longint             hist_pos;

  asd_pkg::out_item_t due_samples [$];
  asd_pkg::out_item_t want;
  int                 fails;
  int                 checked;

  // One code in, one sample out; advances the decoder state.
  function automatic asd_pkg::out_item_t reconstruct(input asd_pkg::in_item_t req);
    longint             span;
    longint             slot;
    longint             code_l;
    longint             diff;
    longint             wide;
    longint             fb;
    longint             mag;
    longint             sum_l;
    longint             t;
    longint             sh;
    logic [31:0]        mag32;
    logic signed [15:0] sample;
    logic signed [15:0] ns;
    asd_pkg::out_item_t res;
    span   = (win_len == 8'd0) ? 1 : win_len;
    slot   = hist_pos % WINDOW_DEPTH;
    code_l = $signed(req.code_in);
    diff   = code_l * step_now;
    wide   = diff + pred_now;
    sample = wide[15:0];
    fb     = (longint'(pred_gain) * longint'(last_sample)) / 32768;
    wide   = longint'(sample) - fb;
    pred_now    = wide[15:0];
    last_sample = sample;
    mag    = (diff < 0) ? -diff : diff;
    mag32  = mag[31:0];
    mag_sum = mag_sum - {16'd0, mag_hist[slot]} + mag32;
    mag_hist[slot] = mag32[15:0];
    sum_l  = mag_sum;
    t      = (sum_l * longint'(step_gain)) / span;
    sh     = t >>> asd_pkg::Q_SHIFT;
    ns     = sh[15:0];
    step_now = (ns == 16'sd0) ? 16'sd1 : ns;
    hist_pos = (hist_pos + 1) % span;
    res.sample_out    = sample;
    res.block_end_out = req.block_end;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pred_gain   = 16'sd0;
      step_gain   = 16'sd32767;
      win_len     = 8'd1;
      step_now    = 16'sd1;
      pred_now    = 16'sd0;
      last_sample = 16'sd0;
      mag_sum     = 32'd0;
      hist_pos    = 0;
      foreach (mag_hist[i]) mag_hist[i] = 16'd0;
      due_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_samples.size() == 0) begin
          $error("sample %0d returned with no request outstanding", out_data.sample_out);
          fails++;
        end else begin
          want = due_samples.pop_front();
          checked++;
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out,
                   out_data.sample_out);
            fails++;
          end
          if (out_data.block_end_out !== want.block_end_out) begin
            $error("block_end_out: expected %0b, got %0b", want.block_end_out,
                   out_data.block_end_out);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) due_samples.push_back(reconstruct(in_data));
      if (cfg_en) begin
        case (cfg_index)
          asd_pkg::CFG_PRED_GAIN: pred_gain = cfg_data;
          asd_pkg::CFG_STEP_GAIN: step_gain = cfg_data;
          asd_pkg::CFG_WIN_LEN:   win_len   = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    due_count     <= due_samples.size();
    fail_count    <= fails;
    checked_count <= checked;
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for the adaptive step dequantizer
// Drives code requests and register settings with random idling on both
// channels, including one long output stall; the checker scores the samples.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SQUEEZE_CYCLES = 600;   // long output hold-off
  localparam int DRAIN_CYCLES   = 80;    // comfortably over one request

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  asd_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  asd_pkg::out_item_t             out_data;
  logic                           cfg_en    = 1'b0;
  logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index = asd_pkg::CFG_PRED_GAIN;
  logic [asd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // stimulus controls, shared with the output side
  logic calm        = 1'b0;   // no idling on either side while set
  logic squeeze_req = 1'b0;   // asks the output side for its one long stall

  int fail_count;
  int due_count;
  int checked_count;
  int cycle_count = 0;
  int hold_left   = SQUEEZE_CYCLES;
  int sent        = 0;
  int settings    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_step_dequantizer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  asd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .checked_count (checked_count)
  );

  // Output side: ready low with a chance of roughly 37 in 100, except while calm.
  // Once asked, it holds off for a long stretch so the block backs up and
  // stops taking requests; counted here, in its own process.
  always @(posedge clk) begin
    if (squeeze_req && hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d samples outstanding", cycle_count,
               due_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly small codes so the step stays in a useful range; some mid-size,
  // some fully random (every bit both ways) and the odd full-scale value.
  function automatic logic signed [15:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 16'(int'($urandom_range(30)) - 15);
    if (roll < 75) return 16'(int'($urandom_range(2047)) - 1024);
    if (roll < 95) return 16'($urandom());
    case ($urandom_range(3))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic pick_mark();
    return ($urandom_range(7) == 0);
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    case ($urandom_range(9))
      0:          return 8'd255;
      1:          return 8'd1;
      2:          return 8'd0;
      3, 4, 5:    return 8'($urandom_range(8, 2));
      default:    return 8'($urandom_range(255, 1));
    endcase
  endfunction

  // Offer one code request. Valid is only dropped when a gap is taken, so it
  // never falls and rises in the same step between back-to-back requests.
  task automatic offer(input logic signed [15:0] code, input logic mark);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    // occasional longer gap, so pauses land across the whole request window
    if (!calm && $urandom_range(19) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk);
    end
    in_data.code_in   <= code;
    in_data.block_end <= mark;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Stop offering and wait for every sample to come back, then let the block
  // fall fully idle before any register is touched.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges.
  task automatic configure(input logic signed [15:0] pg, input logic signed [15:0] sg,
                           input logic [7:0] len);
    cfg_en    <= 1'b1;
    cfg_index <= asd_pkg::CFG_PRED_GAIN;
    cfg_data  <= pg;
    @(posedge clk);
    cfg_index <= asd_pkg::CFG_STEP_GAIN;
    cfg_data  <= sg;
    @(posedge clk);
    cfg_index <= asd_pkg::CFG_WIN_LEN;
    cfg_data  <= {8'd0, len};
    @(posedge clk);
    cfg_en    <= 1'b0;
    settings++;
  endtask

  initial begin
    int phase;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values written back explicitly; step starts at one, so the first
    // codes come straight through, then full-scale codes blow the step up
    configure(16'sd0, 16'sd32767, 8'd1);
    offer(16'sd0, 1'b0);
    offer(16'sd1, 1'b0);
    offer(-16'sd1, 1'b1);
    offer(16'sh7fff, 1'b0);
    offer(16'sh8000, 1'b0);
    offer(16'sh7fff, 1'b1);
    offer(16'sh8000, 1'b0);
    offer(16'sd3, 1'b1);
    settle();

    // both gains at the negative extreme over the widest window: step may go
    // negative
    configure(16'sh8000, 16'sh8000, 8'd255);
    offer(16'sh7fff, 1'b0);
    offer(16'sh8000, 1'b0);
    offer(16'sd5, 1'b0);
    offer(-16'sd5, 1'b1);
    offer(16'sd1, 1'b0);
    offer(16'sh7fff, 1'b1);
    settle();

    // a window length of zero behaves as one
    configure(16'sh7fff, 16'sh7fff, 8'd0);
    offer(16'sd7, 1'b0);
    offer(-16'sd7, 1'b0);
    offer(16'sh8000, 1'b1);
    offer(16'sd2, 1'b0);
    offer(16'sh7fff, 1'b1);
    settle();

    // walk the position well up a long window, then shrink the window under it
    // so the position sits beyond the end and has to wrap
    configure(16'sd16384, 16'sd20000, 8'd200);
    repeat (40) offer(pick_code(), pick_mark());
    settle();
    configure(16'sd16384, 16'sd20000, 8'd3);
    repeat (6) offer(pick_code(), pick_mark());
    settle();

    // random settings, including the extremes; phase 1 carries the long output
    // stall, phase 4 runs with no idling at all
    for (phase = 0; phase < 7; phase++) begin
      configure(pick_gain(), pick_gain(), pick_len());
      if (phase == 4) calm <= 1'b1;
      for (n = 0; n < 100; n++) begin
        if (phase == 1 && n == 10) squeeze_req <= 1'b1;
        offer(pick_code(), pick_mark());
      end
      calm <= 1'b0;
      settle();
    end

    $display("%0d code requests over %0d register settings, %0d samples checked",
             sent, settings, checked_count);
    $display("extreme gains, lengths 0 to 255, a shrunk window, a %0d-cycle output stall",
             SQUEEZE_CYCLES);
    if (fail_count == 0 && due_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
